// File: rtl/scl_pkg.sv
// Shared types, codes and address helpers for the sector cache tag engine.
// Depends on nothing; the scan unit, controller, checker and testbench import it.
`default_nettype none

package scl_pkg;

  // Request codes carried in the input beat.
  localparam logic [1:0] REQ_GET         = 2'd0;
  localparam logic [1:0] REQ_MARK_DIRTY  = 2'd1;
  localparam logic [1:0] REQ_FLUSH_SECT  = 2'd2;
  localparam logic [1:0] REQ_FLUSH_ALL   = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_WB     = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SECTOR_COUNT = 2'd0;
  localparam logic [1:0] CFG_BASE_ADDRESS = 2'd1;
  localparam logic [1:0] CFG_SECTOR_LOG2  = 2'd2;
  localparam logic [1:0] CFG_LINE_LOG2    = 2'd3;

  localparam logic [3:0]  SECTOR_LOG2_RESET = 4'd9;
  localparam logic [31:0] STAMP_LIMIT       = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] sector_index;
    logic        use_lru;
    logic        for_write;
  } scl_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  line_slot;
    logic        hit;
    logic        fill_needed;
    logic [31:0] device_address;
    logic [15:0] byte_offset;
    logic        last;
  } scl_rsp_t;

  // Byte address on the device of a line that starts at the given sector.
  function automatic logic [31:0] line_addr(input logic [31:0] base,
                                            input logic [31:0] first,
                                            input logic [3:0]  ssl);
    logic [31:0] shifted;
    shifted = first << ssl;
    return base + shifted;
  endfunction

  // Offset of a sector within the line buffer, kept to 16 bits.
  function automatic logic [15:0] sector_off(input logic [31:0] sector,
                                             input logic [31:0] first,
                                             input logic [3:0]  ssl);
    logic [31:0] diff;
    logic [31:0] shifted;
    diff    = sector - first;
    shifted = diff << ssl;
    return shifted[15:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/scl_line_mem.sv
// Per-line first sector and age stamp storage, one write and one registered read port.
// Depends on nothing outside this file.
`default_nettype none

module scl_line_mem #(
  parameter int LINES = 8,
  parameter int IW    = 3
) (
  input  wire logic          clk,
  input  wire logic [IW-1:0] rd_addr,
  output logic [31:0]        rd_first,
  output logic [31:0]        rd_stamp,
  input  wire logic          we_first,
  input  wire logic          we_stamp,
  input  wire logic [IW-1:0] wr_addr,
  input  wire logic [31:0]   wr_first,
  input  wire logic [31:0]   wr_stamp
);

  logic [31:0] first_mem [LINES];
  logic [31:0] stamp_mem [LINES];

  always_ff @(posedge clk) begin
    if (we_first) begin
      first_mem[wr_addr] <= wr_first;
    end
    if (we_stamp) begin
      stamp_mem[wr_addr] <= wr_stamp;
    end
    rd_first <= first_mem[rd_addr];
    rd_stamp <= stamp_mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: rtl/scl_scan_unit.sv
// Shared line evaluator: takes one line per cycle and keeps the hit and victim candidates.
// Depends on scl_pkg for the stamp limit.
`default_nettype none

module scl_scan_unit #(
  parameter int IW = 3
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          clr,
  input  wire logic          ev,
  input  wire logic [IW-1:0] ev_idx,
  input  wire logic          ev_valid,
  input  wire logic          ev_dirty,
  input  wire logic [31:0]   ev_first,
  input  wire logic [31:0]   ev_stamp,
  input  wire logic [31:0]   sector,
  input  wire logic [2:0]    lsl,
  input  wire logic          use_lru,
  input  wire logic [31:0]   stamp_ctr,
  output logic               hit_found,
  output logic [IW-1:0]      hit_slot,
  output logic [IW-1:0]      victim_slot
);
  import scl_pkg::*;

  logic          hit_r, hit_nxt;
  logic [IW-1:0] hit_slot_r, hit_slot_nxt;
  logic          inv_r, inv_nxt;
  logic [IW-1:0] inv_slot_r, inv_slot_nxt;
  logic          best_r, best_nxt;
  logic [IW-1:0] best_slot_r, best_slot_nxt;
  logic [31:0]   best_stamp_r, best_stamp_nxt;
  logic          clean_r, clean_nxt;
  logic [IW-1:0] clean_slot_r, clean_slot_nxt;
  logic [31:0]   clean_stamp_r, clean_stamp_nxt;

  logic [31:0] diff;
  logic [31:0] diff_hi;
  logic        in_line;

  assign diff    = sector - ev_first;
  assign diff_hi = diff >> lsl;
  assign in_line = ev_valid && (sector >= ev_first) && (diff_hi == 32'd0);

  always_comb begin
    hit_nxt         = hit_r;
    hit_slot_nxt    = hit_slot_r;
    inv_nxt         = inv_r;
    inv_slot_nxt    = inv_slot_r;
    best_nxt        = best_r;
    best_slot_nxt   = best_slot_r;
    best_stamp_nxt  = best_stamp_r;
    clean_nxt       = clean_r;
    clean_slot_nxt  = clean_slot_r;
    clean_stamp_nxt = clean_stamp_r;
    if (clr) begin
      hit_nxt         = 1'b0;
      inv_nxt         = 1'b0;
      best_nxt        = 1'b0;
      clean_nxt       = 1'b0;
      best_stamp_nxt  = use_lru ? STAMP_LIMIT : 32'd0;
      clean_stamp_nxt = STAMP_LIMIT;
    end else if (ev) begin
      if (!hit_r && in_line) begin
        hit_nxt      = 1'b1;
        hit_slot_nxt = ev_idx;
      end
      // Lines after the first free one no longer count for replacement.
      if (!inv_r) begin
        if (!ev_valid) begin
          inv_nxt      = 1'b1;
          inv_slot_nxt = ev_idx;
        end else if (use_lru) begin
          if (ev_stamp < best_stamp_r) begin
            best_nxt       = 1'b1;
            best_slot_nxt  = ev_idx;
            best_stamp_nxt = ev_stamp;
          end
          if (!ev_dirty && ev_stamp < clean_stamp_r) begin
            clean_nxt       = 1'b1;
            clean_slot_nxt  = ev_idx;
            clean_stamp_nxt = ev_stamp;
          end
        end else if (ev_stamp > best_stamp_r) begin
          best_nxt       = 1'b1;
          best_slot_nxt  = ev_idx;
          best_stamp_nxt = ev_stamp;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r   <= 1'b0;
      inv_r   <= 1'b0;
      best_r  <= 1'b0;
      clean_r <= 1'b0;
    end else begin
      hit_r   <= hit_nxt;
      inv_r   <= inv_nxt;
      best_r  <= best_nxt;
      clean_r <= clean_nxt;
    end
    hit_slot_r    <= hit_slot_nxt;
    inv_slot_r    <= inv_slot_nxt;
    best_slot_r   <= best_slot_nxt;
    best_stamp_r  <= best_stamp_nxt;
    clean_slot_r  <= clean_slot_nxt;
    clean_stamp_r <= clean_stamp_nxt;
  end

  assign hit_found = hit_r;
  assign hit_slot  = hit_slot_r;

  always_comb begin
    if (inv_r) begin
      victim_slot = inv_slot_r;
    end else if (clean_r && clean_stamp_r != stamp_ctr) begin
      victim_slot = clean_slot_r;
    end else if (best_r) begin
      victim_slot = best_slot_r;
    end else begin
      victim_slot = '0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sector_cache_lru_controller.sv
// A get, or mark dirty or flush sector on a hit, runs decode, a scan of every line, pick,
// read-back and a beat state; a miss on mark dirty or flush sector ends after pick, a refused
// get after decode, and flush all walks the lines with a write-back per dirty one. Output
// stalls hold the beat states. The next request is taken the cycle after the final beat is
// loaded. Synchronous active-low reset clears the line flags, sets the stamp counter to one
// and restores the configuration; the tag and stamp memories are not cleared.
`default_nettype none

module sector_cache_lru_controller #(
  parameter int LINES = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire scl_pkg::scl_req_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output scl_pkg::scl_rsp_t     out_data,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [31:0]      cfg_wdata
);
  import scl_pkg::*;

  // Index width for a line, and a counter wide enough to hold LINES itself.
  localparam int IW = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int CW = $clog2(LINES + 1);
  localparam logic [CW-1:0] LAST_CNT = CW'(LINES);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_PICK,
    ST_FETCH,
    ST_FILL,
    ST_DONE,
    ST_FA_RD,
    ST_FA_WB,
    ST_LAST
  } state_t;

  // Configuration registers.
  logic [31:0] sector_count_r;
  logic [31:0] base_address_r;
  logic [3:0]  ssl_r;
  logic [2:0]  lsl_r;

  // Sequencer and line state.
  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  scl_req_t      req_r, req_nxt;
  logic [IW-1:0] tgt_r, tgt_nxt;
  logic          hit_r, hit_nxt;
  logic [LINES-1:0] valid_r, valid_nxt;
  logic [LINES-1:0] dirty_r, dirty_nxt;
  logic [31:0]   stamp_ctr_r, stamp_ctr_nxt;
  logic          out_valid_r, out_valid_nxt;
  scl_rsp_t      out_data_r, out_data_nxt;

  // Memory and scan unit hookup.
  logic [IW-1:0] rd_addr;
  logic [31:0]   rd_first;
  logic [31:0]   rd_stamp;
  logic          we_first;
  logic          we_stamp;
  logic [31:0]   wr_first;
  logic [31:0]   wr_stamp;
  logic          scan_clr;
  logic          scan_ev;
  logic [IW-1:0] ev_idx;
  logic          scan_hit;
  logic [IW-1:0] scan_hit_slot;
  logic [IW-1:0] scan_victim;

  logic [CW-1:0] cnt_m1;
  logic [IW-1:0] cnt_idx;
  logic          out_free;
  logic [31:0]   line_mask;
  logic [31:0]   new_first;
  logic [IW+2:0] tgt_wide;
  logic [IW+2:0] cnt_wide;

  assign cnt_m1    = cnt_r - 1'b1;
  assign ev_idx    = cnt_m1[IW-1:0];
  assign cnt_idx   = cnt_r[IW-1:0];
  assign out_free  = !out_valid_r || !out_stall;
  assign line_mask = (32'd1 << lsl_r) - 32'd1;
  assign new_first = req_r.sector_index & ~line_mask;
  assign wr_first  = new_first;
  assign wr_stamp  = stamp_ctr_r + 32'd1;
  // The result carries the low three bits of the slot number.
  assign tgt_wide  = {3'b000, tgt_r};
  assign cnt_wide  = {3'b000, cnt_idx};

  scl_line_mem #(
    .LINES (LINES),
    .IW    (IW)
  ) u_mem (
    .clk      (clk),
    .rd_addr  (rd_addr),
    .rd_first (rd_first),
    .rd_stamp (rd_stamp),
    .we_first (we_first),
    .we_stamp (we_stamp),
    .wr_addr  (tgt_r),
    .wr_first (wr_first),
    .wr_stamp (wr_stamp)
  );

  scl_scan_unit #(
    .IW (IW)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .clr         (scan_clr),
    .ev          (scan_ev),
    .ev_idx      (ev_idx),
    .ev_valid    (valid_r[ev_idx]),
    .ev_dirty    (dirty_r[ev_idx]),
    .ev_first    (rd_first),
    .ev_stamp    (rd_stamp),
    .sector      (req_r.sector_index),
    .lsl         (lsl_r),
    .use_lru     (req_r.use_lru),
    .stamp_ctr   (stamp_ctr_r),
    .hit_found   (scan_hit),
    .hit_slot    (scan_hit_slot),
    .victim_slot (scan_victim)
  );

  // Sequencer. A request decodes; all but a refused get or flush all scan the lines once through
  // the shared evaluator, read back a hit or a get's victim, then produce write-back and final
  // beats; flush all walks the lines instead. A state that emits a beat waits until the output
  // register is free, and makes its flag and memory updates in the cycle that loads the beat.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    req_nxt       = req_r;
    tgt_nxt       = tgt_r;
    hit_nxt       = hit_r;
    valid_nxt     = valid_r;
    dirty_nxt     = dirty_r;
    stamp_ctr_nxt = stamp_ctr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    rd_addr       = tgt_r;
    we_first      = 1'b0;
    we_stamp      = 1'b0;
    scan_clr      = 1'b0;
    scan_ev       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = ST_DECODE;
        end
      end

      ST_DECODE: begin
        cnt_nxt = '0;
        if (req_r.req_type == REQ_FLUSH_ALL) begin
          state_nxt = ST_FA_RD;
        end else if (req_r.req_type == REQ_GET &&
                     req_r.sector_index >= sector_count_r) begin
          state_nxt = ST_LAST;
        end else begin
          scan_clr  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Address k is read while line k - 1 is evaluated from the read register.
        rd_addr = (cnt_r < LAST_CNT) ? cnt_idx : '0;
        scan_ev = (cnt_r != '0);
        if (cnt_r == LAST_CNT) begin
          state_nxt = ST_PICK;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_PICK: begin
        hit_nxt = scan_hit;
        if (scan_hit) begin
          tgt_nxt   = scan_hit_slot;
          rd_addr   = scan_hit_slot;
          state_nxt = ST_FETCH;
        end else if (req_r.req_type == REQ_GET) begin
          tgt_nxt   = scan_victim;
          rd_addr   = scan_victim;
          state_nxt = ST_FETCH;
        end else begin
          state_nxt = ST_LAST;
        end
      end

      ST_FETCH: begin
        case (req_r.req_type)
          REQ_GET: begin
            if (hit_r) begin
              if (req_r.for_write) begin
                dirty_nxt[tgt_r] = 1'b1;
              end
              if (rd_stamp != stamp_ctr_r) begin
                stamp_ctr_nxt = stamp_ctr_r + 32'd1;
                we_stamp      = 1'b1;
              end
              state_nxt = ST_DONE;
            end else if (valid_r[tgt_r] && dirty_r[tgt_r]) begin
              if (out_free) begin
                out_valid_nxt               = 1'b1;
                out_data_nxt                = '0;
                out_data_nxt.kind           = KIND_WB;
                out_data_nxt.line_slot      = tgt_wide[2:0];
                out_data_nxt.device_address = line_addr(base_address_r, rd_first, ssl_r);
                state_nxt                   = ST_FILL;
              end
            end else begin
              state_nxt = ST_FILL;
            end
          end
          REQ_MARK_DIRTY: begin
            dirty_nxt[tgt_r] = 1'b1;
            state_nxt        = ST_DONE;
          end
          REQ_FLUSH_SECT: begin
            if (dirty_r[tgt_r]) begin
              if (out_free) begin
                out_valid_nxt               = 1'b1;
                out_data_nxt                = '0;
                out_data_nxt.kind           = KIND_WB;
                out_data_nxt.line_slot      = tgt_wide[2:0];
                out_data_nxt.device_address = line_addr(base_address_r, rd_first, ssl_r);
                dirty_nxt[tgt_r]            = 1'b0;
                state_nxt                   = ST_DONE;
              end
            end else begin
              state_nxt = ST_DONE;
            end
          end
          default: begin
            state_nxt = ST_LAST;
          end
        endcase
      end

      ST_FILL: begin
        // The victim is retagged, stamped as the newest line and reported with a fill.
        if (out_free) begin
          we_first                    = 1'b1;
          we_stamp                    = 1'b1;
          stamp_ctr_nxt               = stamp_ctr_r + 32'd1;
          valid_nxt[tgt_r]            = 1'b1;
          dirty_nxt[tgt_r]            = req_r.for_write;
          out_valid_nxt               = 1'b1;
          out_data_nxt                = '0;
          out_data_nxt.kind           = KIND_DONE;
          out_data_nxt.line_slot      = tgt_wide[2:0];
          out_data_nxt.fill_needed    = 1'b1;
          out_data_nxt.device_address = line_addr(base_address_r, new_first, ssl_r);
          out_data_nxt.byte_offset    = sector_off(req_r.sector_index, new_first, ssl_r);
          out_data_nxt.last           = 1'b1;
          state_nxt                   = ST_IDLE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt                = '0;
          out_data_nxt.kind           = KIND_DONE;
          out_data_nxt.line_slot      = tgt_wide[2:0];
          out_data_nxt.hit            = 1'b1;
          out_data_nxt.device_address = line_addr(base_address_r, rd_first, ssl_r);
          out_data_nxt.byte_offset    = sector_off(req_r.sector_index, rd_first, ssl_r);
          out_data_nxt.last           = 1'b1;
          state_nxt                   = ST_IDLE;
        end
      end

      ST_FA_RD: begin
        rd_addr = cnt_idx;
        if (cnt_r == LAST_CNT) begin
          state_nxt = ST_LAST;
        end else if (valid_r[cnt_idx] && dirty_r[cnt_idx]) begin
          state_nxt = ST_FA_WB;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_FA_WB: begin
        // Dirty flags stay set after a flush of the whole cache.
        rd_addr = cnt_idx;
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt                = '0;
          out_data_nxt.kind           = KIND_WB;
          out_data_nxt.line_slot      = cnt_wide[2:0];
          out_data_nxt.device_address = line_addr(base_address_r, rd_first, ssl_r);
          cnt_nxt                     = cnt_r + 1'b1;
          state_nxt                   = ST_FA_RD;
        end
      end

      ST_LAST: begin
        // Final beat without a line: a rejected get, a miss, or the end of flush all.
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_data_nxt      = '0;
          out_data_nxt.kind = (req_r.req_type == REQ_GET) ? KIND_REJECT : KIND_DONE;
          out_data_nxt.last = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      cnt_r          <= '0;
      valid_r        <= '0;
      dirty_r        <= '0;
      stamp_ctr_r    <= 32'd1;
      out_valid_r    <= 1'b0;
      sector_count_r <= 32'd0;
      base_address_r <= 32'd0;
      ssl_r          <= SECTOR_LOG2_RESET;
      lsl_r          <= 3'd0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      valid_r     <= valid_nxt;
      dirty_r     <= dirty_nxt;
      stamp_ctr_r <= stamp_ctr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SECTOR_COUNT: sector_count_r <= cfg_wdata;
          CFG_BASE_ADDRESS: base_address_r <= cfg_wdata;
          CFG_SECTOR_LOG2:  ssl_r          <= cfg_wdata[3:0];
          CFG_LINE_LOG2:    lsl_r          <= cfg_wdata[2:0];
          default: ;
        endcase
      end
    end
    req_r      <= req_nxt;
    tgt_r      <= tgt_nxt;
    hit_r      <= hit_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: rtl/scl_checker.sv
// Port-level checks for the sector cache tag engine, bound to the top level.
// Depends on scl_pkg for the result type and kind codes.
`default_nettype none

module scl_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire scl_pkg::scl_rsp_t out_data
);
  import scl_pkg::*;

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // Only the final beat of a request is marked last, and write-backs never are.
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last == (out_data.kind != KIND_WB)))
    else $error("last flag does not match result kind");

  // A rejected request carries no line information.
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_REJECT |->
      out_data.line_slot == 3'd0 && !out_data.hit && !out_data.fill_needed &&
      out_data.device_address == 32'd0 && out_data.byte_offset == 16'd0)
    else $error("rejected result carries line data");

  // Once a request is taken the block holds off the next one.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request accepted while one is in flight");

endmodule

bind sector_cache_lru_controller scl_checker u_scl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the sector cache tag and LRU engine: a shadow of the
// cache predicts every result beat, and directed plus random requests drive the block.
// Depends on rtl/scl_pkg.sv and rtl/sector_cache_lru_controller.sv.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import scl_pkg::*;

  localparam int LINES       = 8;
  localparam int CYCLE_LIMIT = 400000;

  // Shadow copy of the tag store, the stamp counter and the configuration. Each accepted
  // request is played against it at once, and the beats that it must produce are queued
  // until the block delivers them, in order.
  class lru_cache_shadow;
    logic [31:0] sector_count;
    logic [31:0] base_address;
    logic [3:0]  sector_log2;
    logic [2:0]  line_log2;
    bit          valid[LINES];
    bit          dirty[LINES];
    logic [31:0] first_sector[LINES];
    logic [31:0] age[LINES];
    logic [31:0] stamp;
    scl_rsp_t    pending_beats[$];
    int          mismatch_count;

    function new();
      sector_count = '0;
      base_address = '0;
      sector_log2  = SECTOR_LOG2_RESET;
      line_log2    = '0;
      stamp        = 32'd1;
      mismatch_count = 0;
      for (int i = 0; i < LINES; i++) begin
        valid[i] = 1'b0;
        dirty[i] = 1'b0;
        first_sector[i] = '0;
        age[i] = '0;
      end
    endfunction

    function void write_register(logic [1:0] idx, logic [31:0] val);
      case (idx)
        CFG_SECTOR_COUNT: sector_count = val;
        CFG_BASE_ADDRESS: base_address = val;
        CFG_SECTOR_LOG2:  sector_log2  = val[3:0];
        CFG_LINE_LOG2:    line_log2    = val[2:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_beats.size();
    endfunction

    function logic [31:0] line_address(logic [31:0] first);
      return base_address + (first << sector_log2);
    endfunction

    function void push_beat(logic [1:0] kind, int slot, bit hit, bit fill,
                            logic [31:0] addr, logic [15:0] off, bit fin);
      scl_rsp_t b;
      b.kind           = kind;
      b.line_slot      = slot[2:0];
      b.hit            = hit;
      b.fill_needed    = fill;
      b.device_address = addr;
      b.byte_offset    = off;
      b.last           = fin;
      pending_beats.push_back(b);
    endfunction

    // A line holds the sector when it is valid and the sector lies within its span;
    // the span test is done in 64 bits so that a line at the top of the space does not wrap.
    function int lookup(logic [31:0] sector);
      for (int i = 0; i < LINES; i++) begin
        if (valid[i] && sector >= first_sector[i] &&
            {32'd0, sector} < {32'd0, first_sector[i]} + (64'd1 << line_log2))
          return i;
      end
      return -1;
    endfunction

    // A free line wins outright. Otherwise the oldest (or newest) stamped line is taken,
    // and in LRU mode the oldest clean line takes its place unless it was the last touched.
    function int choose_victim(bit lru);
      int          best;
      int          clean;
      logic [31:0] best_stamp;
      logic [31:0] clean_stamp;
      logic [31:0] s;
      best        = -1;
      clean       = -1;
      best_stamp  = lru ? STAMP_LIMIT : 32'd0;
      clean_stamp = best_stamp;
      for (int i = 0; i < LINES; i++) begin
        if (!valid[i])
          return i;
        s = age[i];
        if ((lru && s < best_stamp) || (!lru && s > best_stamp)) begin
          best_stamp = s;
          best = i;
          if (lru && !dirty[i]) begin
            clean = i;
            clean_stamp = s;
          end
        end else if (lru && !dirty[i] && s < clean_stamp) begin
          clean = i;
          clean_stamp = s;
        end
      end
      if (clean >= 0 && clean_stamp != stamp)
        best = clean;
      return (best < 0) ? 0 : best;
    endfunction

    function logic [15:0] offset_in_line(logic [31:0] sector, int slot);
      logic [31:0] shifted;
      shifted = (sector - first_sector[slot]) << sector_log2;
      return shifted[15:0];
    endfunction

    function void note_request(scl_req_t r);
      int          slot;
      bit          hit;
      logic [31:0] mask;
      case (r.req_type)
        REQ_GET: begin
          if (r.sector_index >= sector_count) begin
            push_beat(KIND_REJECT, 0, 1'b0, 1'b0, '0, '0, 1'b1);
            return;
          end
          slot = lookup(r.sector_index);
          hit  = (slot >= 0);
          if (!hit) begin
            slot = choose_victim(r.use_lru);
            if (valid[slot] && dirty[slot])
              push_beat(KIND_WB, slot, 1'b0, 1'b0, line_address(first_sector[slot]),
                        '0, 1'b0);
            mask = (32'd1 << line_log2) - 32'd1;
            first_sector[slot] = r.sector_index & ~mask;
            valid[slot] = 1'b1;
            dirty[slot] = 1'b0;
            stamp = stamp + 32'd1;
            age[slot] = stamp;
          end
          if (r.for_write)
            dirty[slot] = 1'b1;
          if (age[slot] != stamp) begin
            stamp = stamp + 32'd1;
            age[slot] = stamp;
          end
          push_beat(KIND_DONE, slot, hit, !hit, line_address(first_sector[slot]),
                    offset_in_line(r.sector_index, slot), 1'b1);
        end
        REQ_MARK_DIRTY, REQ_FLUSH_SECT: begin
          slot = lookup(r.sector_index);
          if (slot < 0) begin
            push_beat(KIND_DONE, 0, 1'b0, 1'b0, '0, '0, 1'b1);
            return;
          end
          if (r.req_type == REQ_MARK_DIRTY) begin
            dirty[slot] = 1'b1;
          end else if (dirty[slot]) begin
            push_beat(KIND_WB, slot, 1'b0, 1'b0, line_address(first_sector[slot]), '0, 1'b0);
            dirty[slot] = 1'b0;
          end
          push_beat(KIND_DONE, slot, 1'b1, 1'b0, line_address(first_sector[slot]),
                    offset_in_line(r.sector_index, slot), 1'b1);
        end
        default: begin
          // Flush all writes back every dirty line but leaves the dirty flags alone.
          for (int i = 0; i < LINES; i++) begin
            if (valid[i] && dirty[i])
              push_beat(KIND_WB, i, 1'b0, 1'b0, line_address(first_sector[i]), '0, 1'b0);
          end
          push_beat(KIND_DONE, 0, 1'b0, 1'b0, '0, '0, 1'b1);
        end
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] expected, logic [31:0] actual);
      if (actual !== expected) begin
        $error("%s: expected %0h, got %0h", name, expected, actual);
        mismatch_count++;
      end
    endfunction

    function void check_beat(scl_rsp_t b);
      scl_rsp_t e;
      if (pending_beats.size() == 0) begin
        $error("result beat with nothing expected: %p", b);
        mismatch_count++;
        return;
      end
      e = pending_beats.pop_front();
      compare_field("kind", e.kind, b.kind);
      compare_field("line_slot", e.line_slot, b.line_slot);
      compare_field("hit", e.hit, b.hit);
      compare_field("fill_needed", e.fill_needed, b.fill_needed);
      compare_field("device_address", e.device_address, b.device_address);
      compare_field("byte_offset", e.byte_offset, b.byte_offset);
      compare_field("last", e.last, b.last);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  scl_req_t    in_data;
  logic        out_valid;
  logic        out_stall;
  scl_rsp_t    out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  int send_idle_pct;
  int recv_stall_pct;
  int cycles;

  lru_cache_shadow shadow = new();

  sector_cache_lru_controller #(.LINES(LINES)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure rather than running on for ever.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** sector_cache_lru_controller: FAILED **");
      $finish;
    end
  end

  // The receiver stalls at random; the rate is set per phase by the stimulus process.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Every result beat that the receiver takes is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      shadow.check_beat(out_data);
  end

  function automatic scl_req_t make_request(logic [1:0] kind, logic [31:0] sector,
                                            bit lru, bit wr);
    scl_req_t r;
    r.req_type     = kind;
    r.sector_index = sector;
    r.use_lru      = lru;
    r.for_write    = wr;
    return r;
  endfunction

  // Offers one request beat after a random number of idle cycles and holds it steady
  // until the block takes it. Valid stays high into the next beat when no idle follows.
  task automatic send_request(scl_req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= r;
    do
      @(posedge clk);
    while (in_stall);
    shadow.note_request(r);
  endtask

  // Drops valid and waits until every expected result beat has been taken. Every request
  // ends in a final beat, so at that point the block holds no work at all.
  task automatic wait_until_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (shadow.pending() != 0)
      @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    shadow.write_register(idx, val);
  endtask

  // Reconfiguration only ever happens with the block drained.
  task automatic configure(logic [31:0] count, logic [31:0] base, int ssl, int lsl);
    wait_until_idle();
    write_register(CFG_SECTOR_COUNT, count);
    write_register(CFG_BASE_ADDRESS, base);
    write_register(CFG_SECTOR_LOG2, ssl);
    write_register(CFG_LINE_LOG2, lsl);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random traffic mostly hits a small window of sectors, a little wider than the cache,
  // so that hits, evictions and write-backs all come often. The sector count sits just
  // below the top of the window so that some gets are rejected. One beat in ten carries
  // a fully random sector to stir every bit of the index.
  task automatic random_phase(int items, int send_pct, int recv_pct);
    logic [31:0] anchor;
    logic [31:0] window;
    scl_req_t    r;
    int          pick;
    int          lsl;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    lsl    = $urandom_range(0, 4);
    anchor = $urandom_range(32'hFFFF_0000, 0);
    window = (LINES + 3) << lsl;
    configure(anchor + window - (window >> 3), $urandom, $urandom_range(9, 12), lsl);
    for (int i = 0; i < items; i++) begin
      // Now and then, and always once mid-phase, the sender waits for the block to drain.
      if (i == items / 2 || $urandom_range(0, 99) < 3)
        wait_until_idle();
      pick = $urandom_range(0, 99);
      if (pick < 60)
        r.req_type = REQ_GET;
      else if (pick < 75)
        r.req_type = REQ_MARK_DIRTY;
      else if (pick < 92)
        r.req_type = REQ_FLUSH_SECT;
      else
        r.req_type = REQ_FLUSH_ALL;
      if ($urandom_range(0, 9) == 0)
        r.sector_index = $urandom;
      else
        r.sector_index = anchor + $urandom_range(0, window - 1);
      r.use_lru   = $urandom_range(0, 1);
      r.for_write = $urandom_range(0, 1);
      send_request(r);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_SECTOR_COUNT;
    cfg_wdata      = '0;
    cycles         = 0;
    send_idle_pct  = 11;
    recv_stall_pct = 68;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // With no sectors on the device every get is refused; the other requests find no valid line.
    configure(32'd0, 32'd0, 9, 0);
    send_request(make_request(REQ_GET, 32'd0, 1'b1, 1'b1));
    send_request(make_request(REQ_MARK_DIRTY, 32'd0, 1'b0, 1'b0));
    send_request(make_request(REQ_FLUSH_SECT, 32'd0, 1'b0, 1'b0));
    send_request(make_request(REQ_FLUSH_ALL, 32'd0, 1'b0, 1'b0));

    // Sectors of 2^12 bytes and lines of 16 sectors at the very top of the space: device addresses wrap.
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 12, 4);
    send_request(make_request(REQ_GET, 32'hFFFF_FFFF, 1'b1, 1'b1));
    send_request(make_request(REQ_GET, 32'hFFFF_FFFE, 1'b1, 1'b1));
    send_request(make_request(REQ_GET, 32'hFFFF_FFF0, 1'b0, 1'b0));
    send_request(make_request(REQ_GET, 32'd0, 1'b0, 1'b0));
    send_request(make_request(REQ_MARK_DIRTY, 32'd5, 1'b0, 1'b0));
    send_request(make_request(REQ_FLUSH_SECT, 32'd3, 1'b0, 1'b0));
    send_request(make_request(REQ_FLUSH_SECT, 32'd3, 1'b1, 1'b1));
    // Fill the remaining lines, half of them dirty, then force evictions both ways.
    for (int i = 1; i <= 6; i++)
      send_request(make_request(REQ_GET, 32'(i * 16), 1'b1, i[0]));
    send_request(make_request(REQ_GET, 32'd200, 1'b1, 1'b0));
    send_request(make_request(REQ_GET, 32'd300, 1'b0, 1'b1));
    send_request(make_request(REQ_GET, 32'd300, 1'b1, 1'b0));
    send_request(make_request(REQ_FLUSH_ALL, 32'hFFFF_FFFF, 1'b1, 1'b1));
    send_request(make_request(REQ_GET, 32'hFFFF_FFFE, 1'b1, 1'b0));
    send_request(make_request(REQ_FLUSH_ALL, 32'd0, 1'b0, 1'b0));

    random_phase(73, 11, 68);
    random_phase(73, 68, 11);
    random_phase(74, 0, 0);

    wait_until_idle();
    repeat (LINES + 12) @(posedge clk);
    if (shadow.mismatch_count == 0 && shadow.pending() == 0)
      $display("** sector_cache_lru_controller: PASSED **");
    else
      $display("** sector_cache_lru_controller: FAILED **");
    $finish;
  end

endmodule
